// ===== rtl/crcf_pkg.sv =====
package crcf_pkg;

  localparam int MAX_DIM_DEF = 256;

  localparam int CW   = 9;
  localparam int DW   = 17;
  localparam int SQW  = 31;
  localparam int MW   = 18;
  localparam int CNTW = 17;
  localparam int QDEPTH = 2;
  localparam int QPW  = $clog2(QDEPTH);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    REQ_RECT   = 2'd0,
    REQ_CIRCLE = 2'd1,
    REQ_READ   = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_R2,
    B_DX,
    B_DY,
    B_BASE,
    B_ADDR,
    B_RUN,
    B_READ,
    B_RDOUT,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic                 is_read;
    logic                 is_circle;
    logic                 empty;
    logic [CW-1:0]        x0;
    logic [CW-1:0]        y0;
    logic [CW-1:0]        x_last;
    logic [CW-1:0]        y_last;
    logic signed [DW-1:0] dx0;
    logic signed [DW-1:0] dy0;
    logic [14:0]          radius;
    logic [31:0]          color;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [31:0]     pixel;
    logic            in_frame;
    logic [CNTW-1:0] pixels_written;
  } res_t;

  // (d+1)^2 - d^2 = 2d+1, sign extended to the square width
  function automatic logic [SQW-1:0] odd_step(logic signed [DW-1:0] d);
    logic signed [DW:0] t;
    t = {d, 1'b1};
    return SQW'(t);
  endfunction

endpackage

// ===== rtl/crcf_front.sv =====
module crcf_front (
  input  logic [1:0]            req_type_i,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic signed [15:0]    size_w_i,
  input  logic signed [15:0]    size_h_i,
  input  logic [14:0]           radius_i,
  input  logic [7:0]            color_b_i,
  input  logic [7:0]            color_g_i,
  input  logic [7:0]            color_r_i,
  input  logic [7:0]            color_a_i,
  input  logic [crcf_pkg::CW-1:0] fw_i,
  input  logic [crcf_pkg::CW-1:0] fh_i,
  output crcf_pkg::cmd_t        cmd_o
);

  logic signed [17:0] px_s, py_s, r_s, fw_s, fh_s;
  logic signed [17:0] xa, xb, ya, yb;
  logic signed [17:0] x0s, x1s, y0s, y1s, xls, yls;
  logic               box_ok, rd_in;

  assign px_s = 18'(pos_x_i);
  assign py_s = 18'(pos_y_i);
  assign r_s  = $signed({3'b0, radius_i});
  assign fw_s = $signed({9'b0, fw_i});
  assign fh_s = $signed({9'b0, fh_i});

  always_comb begin
    if (req_type_i == crcf_pkg::REQ_CIRCLE) begin
      xa = px_s - r_s;
      xb = px_s + r_s;
      ya = py_s - r_s;
      yb = py_s + r_s;
    end else begin
      xa = px_s;
      xb = px_s + 18'(size_w_i);
      ya = py_s;
      yb = py_s + 18'(size_h_i);
    end
  end

  assign x0s = (xa < 18'sd0) ? 18'sd0 : xa;
  assign y0s = (ya < 18'sd0) ? 18'sd0 : ya;
  assign x1s = (xb < fw_s) ? xb : fw_s;
  assign y1s = (yb < fh_s) ? yb : fh_s;
  assign xls = x1s - 18'sd1;
  assign yls = y1s - 18'sd1;
  assign box_ok = (x0s < x1s) && (y0s < y1s);
  assign rd_in = (px_s >= 18'sd0) && (px_s < fw_s) && (py_s >= 18'sd0) && (py_s < fh_s);

  always_comb begin
    cmd_o.is_read   = 1'b0;
    cmd_o.is_circle = 1'b0;
    cmd_o.empty     = 1'b1;
    cmd_o.x0        = x0s[crcf_pkg::CW-1:0];
    cmd_o.y0        = y0s[crcf_pkg::CW-1:0];
    cmd_o.x_last    = xls[crcf_pkg::CW-1:0];
    cmd_o.y_last    = yls[crcf_pkg::CW-1:0];
    cmd_o.dx0       = crcf_pkg::DW'(x0s - px_s);
    cmd_o.dy0       = crcf_pkg::DW'(y0s - py_s);
    cmd_o.radius    = radius_i;
    cmd_o.color     = {color_a_i, color_r_i, color_g_i, color_b_i};
    unique case (crcf_pkg::req_type_e'(req_type_i))
      crcf_pkg::REQ_RECT: begin
        cmd_o.empty = !box_ok;
      end
      crcf_pkg::REQ_CIRCLE: begin
        cmd_o.is_circle = 1'b1;
        cmd_o.empty     = !box_ok;
      end
      crcf_pkg::REQ_READ: begin
        cmd_o.is_read = 1'b1;
        cmd_o.empty   = !rd_in;
        cmd_o.x0      = px_s[crcf_pkg::CW-1:0];
        cmd_o.y0      = py_s[crcf_pkg::CW-1:0];
      end
      default: begin
        cmd_o.empty = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/crcf_queue.sv =====
module crcf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  crcf_pkg::cmd_t       data_i,
  input  logic                 pop_i,
  output crcf_pkg::q_status_t  status_o,
  output crcf_pkg::cmd_t       data_o
);

  localparam int QCW = $clog2(crcf_pkg::QDEPTH + 1);

  crcf_pkg::cmd_t               ent_q [crcf_pkg::QDEPTH];
  logic [crcf_pkg::QPW-1:0]     wr_q, rd_q;
  logic [QCW-1:0]               cnt_q;
  logic                         do_push, do_pop;

  assign status_o.full  = (cnt_q == QCW'(crcf_pkg::QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (32'(wr_q) == crcf_pkg::QDEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == crcf_pkg::QDEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/crcf_back.sv =====
module crcf_back #(
  parameter int MAX_DIM = crcf_pkg::MAX_DIM_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [crcf_pkg::CW-1:0] fw_i,
  input  crcf_pkg::cmd_t          cmd_i,
  input  crcf_pkg::q_status_t     qst_i,
  output logic                    q_pop_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output crcf_pkg::res_t          res_o
);

  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int SQW = crcf_pkg::SQW;

  crcf_pkg::back_state_e state_q, state_d;
  crcf_pkg::cmd_t        cmd_q;
  crcf_pkg::res_t        res_q, res_d;
  logic                  res_valid_q;

  logic [31:0]           mem_q [MEM_DEPTH];
  logic [31:0]           rdata_q;

  logic signed [crcf_pkg::MW-1:0]   mul_a, mul_b;
  logic signed [2*crcf_pkg::MW-1:0] prod_q;

  logic [SQW-1:0] r2_q, dx0sq_q, dxsq_q, dysq_q;
  logic [crcf_pkg::CW-1:0] x_q, y_q;
  logic signed [crcf_pkg::DW-1:0] dx_q, dy_q;
  logic [AW-1:0] addr_q, row_base_q;
  logic [crcf_pkg::CNTW-1:0] count_q;

  logic hit, x_end, y_end, slot_free, mem_we, mem_re, res_push;

  assign x_end = (x_q == cmd_q.x_last);
  assign y_end = (y_q == cmd_q.y_last);
  assign hit = !cmd_q.is_circle ||
               (({1'b0, dxsq_q} + {1'b0, dysq_q}) < {1'b0, r2_q});
  assign slot_free = !res_valid_q || pop_i;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_push = 1'b0;
    unique case (state_q)
      crcf_pkg::B_IDLE: begin
        if (!qst_i.empty) begin
          q_pop_o = 1'b1;
          state_d = crcf_pkg::B_R2;
        end
      end
      crcf_pkg::B_R2:   state_d = crcf_pkg::B_DX;
      crcf_pkg::B_DX:   state_d = crcf_pkg::B_DY;
      crcf_pkg::B_DY:   state_d = crcf_pkg::B_BASE;
      crcf_pkg::B_BASE: state_d = crcf_pkg::B_ADDR;
      crcf_pkg::B_ADDR: begin
        priority if (cmd_q.empty) state_d = crcf_pkg::B_DONE;
        else if (cmd_q.is_read)   state_d = crcf_pkg::B_READ;
        else                      state_d = crcf_pkg::B_RUN;
      end
      crcf_pkg::B_RUN: begin
        mem_we = hit;
        if (x_end && y_end) state_d = crcf_pkg::B_DONE;
      end
      crcf_pkg::B_READ: begin
        mem_re  = 1'b1;
        state_d = crcf_pkg::B_RDOUT;
      end
      crcf_pkg::B_RDOUT, crcf_pkg::B_DONE: begin
        if (slot_free) begin
          res_push = 1'b1;
          state_d  = crcf_pkg::B_IDLE;
        end
      end
      default: state_d = crcf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= crcf_pkg::B_IDLE;
    else         state_q <= state_d;
  end

  // shared multiplier: r^2, dx0^2, dy0^2, y0*stride
  always_comb begin
    unique case (state_q)
      crcf_pkg::B_R2: begin
        mul_a = $signed({3'b0, cmd_q.radius});
        mul_b = $signed({3'b0, cmd_q.radius});
      end
      crcf_pkg::B_DX: begin
        mul_a = crcf_pkg::MW'($signed(cmd_q.dx0));
        mul_b = crcf_pkg::MW'($signed(cmd_q.dx0));
      end
      crcf_pkg::B_DY: begin
        mul_a = crcf_pkg::MW'($signed(cmd_q.dy0));
        mul_b = crcf_pkg::MW'($signed(cmd_q.dy0));
      end
      default: begin
        mul_a = $signed({9'b0, cmd_q.y0});
        mul_b = $signed({9'b0, fw_i});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= cmd_i;
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      crcf_pkg::B_DX:   r2_q    <= SQW'(prod_q);
      crcf_pkg::B_DY:   dx0sq_q <= SQW'(prod_q);
      crcf_pkg::B_BASE: dysq_q  <= SQW'(prod_q);
      crcf_pkg::B_ADDR: begin
        row_base_q <= AW'(prod_q);
        addr_q     <= AW'(prod_q) + AW'(cmd_q.x0);
        x_q        <= cmd_q.x0;
        y_q        <= cmd_q.y0;
        dx_q       <= cmd_q.dx0;
        dy_q       <= cmd_q.dy0;
        dxsq_q     <= dx0sq_q;
        count_q    <= '0;
      end
      crcf_pkg::B_RUN: begin
        if (hit) count_q <= count_q + 1'b1;
        if (!x_end) begin
          x_q    <= x_q + 1'b1;
          dx_q   <= dx_q + crcf_pkg::DW'(1);
          dxsq_q <= dxsq_q + crcf_pkg::odd_step(dx_q);
          addr_q <= addr_q + 1'b1;
        end else if (!y_end) begin
          y_q        <= y_q + 1'b1;
          dy_q       <= dy_q + crcf_pkg::DW'(1);
          dysq_q     <= dysq_q + crcf_pkg::odd_step(dy_q);
          x_q        <= cmd_q.x0;
          dx_q       <= cmd_q.dx0;
          dxsq_q     <= dx0sq_q;
          row_base_q <= row_base_q + AW'(fw_i);
          addr_q     <= row_base_q + AW'(fw_i) + AW'(cmd_q.x0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr_q] <= cmd_q.color;
    if (mem_re) rdata_q <= mem_q[addr_q];
  end

  always_comb begin
    res_d.pixel          = '0;
    res_d.in_frame       = 1'b0;
    res_d.pixels_written = cmd_q.is_read ? '0 : count_q;
    if (state_q == crcf_pkg::B_RDOUT) begin
      res_d.pixel          = rdata_q;
      res_d.in_frame       = 1'b1;
      res_d.pixels_written = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                    res_valid_q <= 1'b0;
    else if (res_push)              res_valid_q <= 1'b1;
    else if (pop_i && res_valid_q)  res_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_q <= res_d;
  end

  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

  a_scan_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crcf_pkg::B_RUN |-> (x_q <= cmd_q.x_last) && (y_q <= cmd_q.y_last))
    else $error("scan position left the clipped box");

  a_addr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crcf_pkg::B_RUN |-> addr_q == row_base_q + AW'(x_q))
    else $error("pixel address out of step with column");

  a_pop_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == crcf_pkg::B_R2)
    else $error("command taken without setup");

  a_res_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.in_frame && (res_q.pixels_written != '0)))
    else $error("result mixes read and draw fields");

endmodule

// ===== rtl/clipped_rect_circle_fill.sv =====
// Clipped rectangle/circle fill on a 32-bit BGRA frame store of MAX_DIM x MAX_DIM
// words. Commands enter through a push/full queue and each returns one result
// through empty/pop. A draw passes a dispatch step, setup steps on the shared
// 18x18 multiplier (radius squared, the corner offsets squared, the first row
// base), one pixel per cycle of its clipped bounding box (w x h pixels) on the
// single frame store write port, and a step that posts the result once the
// result slot is free; an empty or clipped-away draw skips the pixel step. Up
// to two commands wait in the queue while one is in progress. Frame registers
// are to be written through the APB port only while the block is idle, a rule
// the block has no check for; pixels never written read back as undefined.
module clipped_rect_circle_fill #(
  parameter int MAX_DIM = crcf_pkg::MAX_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] size_w_i,
  input  logic signed [15:0] size_h_i,
  input  logic [14:0]        radius_i,
  input  logic [7:0]         color_b_i,
  input  logic [7:0]         color_g_i,
  input  logic [7:0]         color_r_i,
  input  logic [7:0]         color_a_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         pixel_b_o,
  output logic [7:0]         pixel_g_o,
  output logic [7:0]         pixel_r_o,
  output logic [7:0]         pixel_a_o,
  output logic               in_frame_o,
  output logic [16:0]        pixels_written_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = crcf_pkg::CW;

  logic [CW-1:0] fw_q, fh_q, fw_eff, fh_eff;
  logic          cfg_wr;

  crcf_pkg::cmd_t      front_cmd, q_cmd;
  crcf_pkg::q_status_t qst;
  crcf_pkg::res_t      res;
  logic                q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= CW'(256);
      fh_q <= CW'(256);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        crcf_pkg::REG_FRAME_WIDTH:  fw_q <= pwdata[CW-1:0];
        crcf_pkg::REG_FRAME_HEIGHT: fh_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      crcf_pkg::REG_FRAME_WIDTH:  prdata = {{(32-CW){1'b0}}, fw_q};
      crcf_pkg::REG_FRAME_HEIGHT: prdata = {{(32-CW){1'b0}}, fh_q};
      default:                    prdata = '0;
    endcase
  end

  assign fw_eff = (32'(fw_q) > MAX_DIM) ? CW'(MAX_DIM) : fw_q;
  assign fh_eff = (32'(fh_q) > MAX_DIM) ? CW'(MAX_DIM) : fh_q;

  crcf_front u_front (
    .req_type_i (req_type_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .size_w_i   (size_w_i),
    .size_h_i   (size_h_i),
    .radius_i   (radius_i),
    .color_b_i  (color_b_i),
    .color_g_i  (color_g_i),
    .color_r_i  (color_r_i),
    .color_a_i  (color_a_i),
    .fw_i       (fw_eff),
    .fh_i       (fh_eff),
    .cmd_o      (front_cmd)
  );

  crcf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (front_cmd),
    .pop_i    (q_pop),
    .status_o (qst),
    .data_o   (q_cmd)
  );

  crcf_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fw_i    (fw_eff),
    .cmd_i   (q_cmd),
    .qst_i   (qst),
    .q_pop_o (q_pop),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res)
  );

  assign full             = qst.full;
  assign pixel_b_o        = res.pixel[7:0];
  assign pixel_g_o        = res.pixel[15:8];
  assign pixel_r_o        = res.pixel[23:16];
  assign pixel_a_o        = res.pixel[31:24];
  assign in_frame_o       = res.in_frame;
  assign pixels_written_o = res.pixels_written;

endmodule

// ===== verif/clipped_rect_circle_fill_tb.sv =====
`timescale 1ns / 100ps

module clipped_rect_circle_fill_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int FB_WORDS = crcf_pkg::MAX_DIM_DEF * crcf_pkg::MAX_DIM_DEF;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [14:0] r;
    logic [31:0] color;
    logic        aim;
    logic        drain;
  } draw_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  draw_cmd_t   drv = '0;

  logic [1:0]         req_type_i;
  logic signed [15:0] pos_x_i, pos_y_i, size_w_i, size_h_i;
  logic [14:0]        radius_i;
  logic [7:0]         color_b_i, color_g_i, color_r_i, color_a_i;
  logic [7:0]         pixel_b_o, pixel_g_o, pixel_r_o, pixel_a_o;
  logic               in_frame_o;
  logic [16:0]        pixels_written_o;

  assign req_type_i = drv.req;
  assign pos_x_i    = drv.x;
  assign pos_y_i    = drv.y;
  assign size_w_i   = drv.w;
  assign size_h_i   = drv.h;
  assign radius_i   = drv.r;
  assign color_b_i  = drv.color[7:0];
  assign color_g_i  = drv.color[15:8];
  assign color_r_i  = drv.color[23:16];
  assign color_a_i  = drv.color[31:24];

  clipped_rect_circle_fill dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .size_w_i         (size_w_i),
    .size_h_i         (size_h_i),
    .radius_i         (radius_i),
    .color_b_i        (color_b_i),
    .color_g_i        (color_g_i),
    .color_r_i        (color_r_i),
    .color_a_i        (color_a_i),
    .empty            (empty),
    .pop              (pop),
    .pixel_b_o        (pixel_b_o),
    .pixel_g_o        (pixel_g_o),
    .pixel_r_o        (pixel_r_o),
    .pixel_a_o        (pixel_a_o),
    .in_frame_o       (in_frame_o),
    .pixels_written_o (pixels_written_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow frame store and frame registers
  logic [31:0] shadow_fb [FB_WORDS];
  bit          shadow_written [FB_WORDS];
  logic [8:0]  cfg_width = 9'd256;
  logic [8:0]  cfg_height = 9'd256;
  int          hit_x [$];
  int          hit_y [$];

  draw_cmd_t       pending_cmds [$];
  crcf_pkg::res_t  expected_results [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          n_err = 0;
  int          n_cmds = 0;
  int          n_draws = 0;
  int          n_reads = 0;
  int          n_in_frame = 0;
  int          n_settings = 1;
  longint      n_pixels = 0;

  function automatic int eff_dim(logic [8:0] v);
    return (v > crcf_pkg::MAX_DIM_DEF) ? crcf_pkg::MAX_DIM_DEF : int'(v);
  endfunction

  task automatic render_cmd(input draw_cmd_t c, output crcf_pkg::res_t o);
    int fw, fh, px, py, sw, sh, rad, x0, x1, y0, y1, cnt, fx, fy, lx, ly, idx;
    longint r2, dx, dy;
    o = '0;
    fw = eff_dim(cfg_width);
    fh = eff_dim(cfg_height);
    px = $signed(c.x);
    py = $signed(c.y);
    sw = $signed(c.w);
    sh = $signed(c.h);
    rad = c.r;
    cnt = 0;
    fx = -1;
    fy = -1;
    lx = 0;
    ly = 0;
    case (c.req)
      crcf_pkg::REQ_RECT, crcf_pkg::REQ_CIRCLE: begin
        if (c.req == crcf_pkg::REQ_RECT) begin
          x0 = (px > 0) ? px : 0;
          y0 = (py > 0) ? py : 0;
          x1 = (px + sw < fw) ? px + sw : fw;
          y1 = (py + sh < fh) ? py + sh : fh;
        end else begin
          x0 = (px - rad > 0) ? px - rad : 0;
          y0 = (py - rad > 0) ? py - rad : 0;
          x1 = (px + rad < fw) ? px + rad : fw;
          y1 = (py + rad < fh) ? py + rad : fh;
        end
        r2 = longint'(rad) * rad;
        for (int y = y0; y < y1; y++) begin
          for (int x = x0; x < x1; x++) begin
            dx = x - px;
            dy = y - py;
            if (c.req == crcf_pkg::REQ_RECT || dx * dx + dy * dy < r2) begin
              shadow_fb[y * fw + x] = c.color;
              shadow_written[y * fw + x] = 1'b1;
              cnt++;
              if (fx < 0) begin
                fx = x;
                fy = y;
              end
              lx = x;
              ly = y;
            end
          end
        end
        o.pixels_written = cnt[16:0];
        n_draws++;
        n_pixels += cnt;
        if (cnt > 0) begin
          hit_x.push_back(fx);
          hit_y.push_back(fy);
          hit_x.push_back(lx);
          hit_y.push_back(ly);
          while (hit_x.size() > 64) begin
            void'(hit_x.pop_front());
            void'(hit_y.pop_front());
          end
        end
      end
      crcf_pkg::REQ_READ: begin
        n_reads++;
        if (px >= 0 && px < fw && py >= 0 && py < fh) begin
          idx = py * fw + px;
          o.pixel = shadow_fb[idx];
          o.in_frame = 1'b1;
          n_in_frame++;
        end
      end
      default: ;
    endcase
  endtask

  // pick a read position, never one that lands on an unwritten word
  task automatic aim_read(inout draw_cmd_t c);
    int fw, fh, k, x, y, roll;
    fw = eff_dim(cfg_width);
    fh = eff_dim(cfg_height);
    roll = $urandom_range(99);
    if (roll < 60 && hit_x.size() > 0) begin
      k = $urandom_range(hit_x.size() - 1);
      x = hit_x[k] + int'($urandom_range(2)) - 1;
      y = hit_y[k] + int'($urandom_range(2)) - 1;
    end else if (roll < 85) begin
      x = $urandom_range(255);
      y = $urandom_range(255);
    end else if (roll < 92) begin
      x = fw + int'($urandom_range(3));
      y = $urandom_range(255);
    end else begin
      x = $signed(16'($urandom()));
      y = $signed(16'($urandom()));
    end
    if (x >= 0 && x < fw && y >= 0 && y < fh && !shadow_written[y * fw + x])
      x = -1;
    c.x = 16'(x);
    c.y = 16'(y);
  endtask

  function automatic draw_cmd_t random_cmd(int fw, int fh, bit allow_wide);
    draw_cmd_t c;
    int pick;
    bit wide;
    c = '0;
    c.color = $urandom();
    c.w = 16'($urandom());
    c.h = 16'($urandom());
    c.r = 15'($urandom());
    c.x = 16'(int'($urandom_range(fw + 16)) - 8);
    c.y = 16'(int'($urandom_range(fh + 16)) - 8);
    wide = allow_wide && ($urandom_range(9) == 0);
    pick = $urandom_range(99);
    if (pick < 35) begin
      c.req = crcf_pkg::REQ_RECT;
      if (wide) begin
        c.x = 16'($urandom());
        c.y = 16'($urandom());
      end else begin
        c.w = 16'(int'($urandom_range(26)) - 2);
        c.h = 16'(int'($urandom_range(26)) - 2);
      end
    end else if (pick < 65) begin
      c.req = crcf_pkg::REQ_CIRCLE;
      if (wide) begin
        c.x = 16'($urandom());
        c.y = 16'($urandom());
      end else begin
        c.r = 15'($urandom_range(20));
      end
    end else if (pick < 95) begin
      c.req = crcf_pkg::REQ_READ;
      c.aim = 1'b1;
    end else begin
      c.req = REQ_UNUSED;
      c.x = 16'($urandom());
      c.y = 16'($urandom());
    end
    return c;
  endfunction

  function automatic void add_cmd(logic [1:0] req, int x, int y, int w, int h, int r,
                                  logic [31:0] color, bit drain);
    draw_cmd_t c;
    c = '0;
    c.req = req;
    c.x = 16'(x);
    c.y = 16'(y);
    c.w = 16'(w);
    c.h = 16'(h);
    c.r = 15'(r);
    c.color = color;
    c.drain = drain;
    pending_cmds.push_back(c);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      n_err++;
    end
  endfunction

  // driver: a command transfer completes on push && !full
  always @(posedge clk_i) begin : cmd_driver
    draw_cmd_t      nxt;
    crcf_pkg::res_t res;
    if (rst_ni) begin
      if (push && !full) begin
        render_cmd(drv, res);
        expected_results.push_back(res);
        n_cmds++;
      end
      if (!push || !full) begin
        if (pending_cmds.size() > 0 && int'($urandom_range(99)) >= send_idle_pct &&
            !(pending_cmds[0].drain && expected_results.size() != 0)) begin
          nxt = pending_cmds.pop_front();
          if (nxt.aim)
            aim_read(nxt);
          drv <= nxt;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: a result transfer completes on pop && !empty
  always @(posedge clk_i) begin : result_monitor
    crcf_pkg::res_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding");
          n_err++;
        end else begin
          e = expected_results.pop_front();
          check_field("pixel_b", e.pixel[7:0], pixel_b_o);
          check_field("pixel_g", e.pixel[15:8], pixel_g_o);
          check_field("pixel_r", e.pixel[23:16], pixel_r_o);
          check_field("pixel_a", e.pixel[31:24], pixel_a_o);
          check_field("in_frame", e.in_frame, in_frame_o);
          check_field("pixels_written", e.pixels_written, pixels_written_o);
        end
      end
      pop <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || push || expected_results.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin : stimulus
    draw_cmd_t c;
    int nw, nh, fw, fh;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 55;

    // full fill first so every later in-frame read hits a written word
    add_cmd(crcf_pkg::REQ_RECT, 0, 0, 256, 256, 0, 32'hA5C33C5A, 0);
    add_cmd(crcf_pkg::REQ_READ, 0, 0, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, 255, 255, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_RECT, -32768, -32768, 32767, 32767, 32767, 32'hFFFFFFFF, 0);
    add_cmd(crcf_pkg::REQ_RECT, 32767, 32767, 32767, 32767, 0, 32'hFFFFFFFF, 0);
    add_cmd(crcf_pkg::REQ_RECT, 10, 10, 0, 5, 0, 32'h11111111, 0);
    add_cmd(crcf_pkg::REQ_RECT, 10, 10, -32768, -1, 0, 32'h22222222, 0);
    add_cmd(crcf_pkg::REQ_RECT, 250, 250, 100, 100, 0, 32'h00000000, 0);
    add_cmd(crcf_pkg::REQ_RECT, -5, -3, 10, 8, 0, 32'h12345678, 0);
    add_cmd(crcf_pkg::REQ_READ, 255, 255, 0, 0, 0, 32'h0, 1);
    add_cmd(crcf_pkg::REQ_READ, 2, 1, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_CIRCLE, 10, 10, 0, 0, 0, 32'h33333333, 0);
    add_cmd(crcf_pkg::REQ_CIRCLE, 20, 20, 0, 0, 1, 32'h80808080, 0);
    add_cmd(crcf_pkg::REQ_READ, 20, 20, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, 21, 20, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_CIRCLE, 0, 0, 0, 0, 5, 32'h7F01FE10, 0);
    add_cmd(crcf_pkg::REQ_CIRCLE, 32767, -32768, -1, -1, 32767, 32'hFFFFFFFF, 0);
    add_cmd(crcf_pkg::REQ_CIRCLE, 128, 128, 0, 0, 200, 32'h01020304, 0);
    add_cmd(crcf_pkg::REQ_CIRCLE, 100, 100, 0, 0, 30, 32'hFEDCBA98, 0);
    add_cmd(crcf_pkg::REQ_READ, 100, 100, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, 130, 100, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, 129, 100, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, -1, 0, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, 0, -32768, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, 256, 0, 0, 0, 0, 32'h0, 0);
    add_cmd(crcf_pkg::REQ_READ, 32767, 255, 0, 0, 0, 32'h0, 0);
    add_cmd(REQ_UNUSED, -1, 32767, -32768, 32767, 21845, 32'hC0FFEE00, 0);
    settle();

    for (int s = 0; s < 7; s++) begin
      if (s == 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 37;
      end else if (s == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (s)
        0: begin nw = 48;  nh = 40;  end
        1: begin nw = 1;   nh = 256; end
        2: begin nw = 511; nh = 300; end
        3: begin nw = 0;   nh = 17;  end
        4: begin nw = 256; nh = 1;   end
        5: begin nw = 257; nh = 64;  end
        default: begin nw = 100; nh = 75; end
      endcase
      apb_write({crcf_pkg::REG_FRAME_WIDTH, 2'b00}, 32'(nw));
      cfg_width = nw[8:0];
      apb_write({crcf_pkg::REG_FRAME_HEIGHT, 2'b00}, 32'(nh));
      cfg_height = nh[8:0];
      n_settings++;
      fw = eff_dim(cfg_width);
      fh = eff_dim(cfg_height);
      // big random shapes only where the frame keeps them cheap
      for (int i = 0; i < 16; i++) begin
        c = random_cmd(fw, fh, fw * fh <= 8192);
        c.drain = (i == 8);
        pending_cmds.push_back(c);
      end
      settle();
    end

    $display("checked %0d commands: %0d draws writing %0d pixels, %0d reads (%0d in frame)",
             n_cmds, n_draws, n_pixels, n_reads, n_in_frame);
    $display("across %0d frame size settings with sender/receiver stalls and drain pauses",
             n_settings);
    if (n_err == 0) begin
      $display("clipped_rect_circle_fill_tb: clean");
    end else begin
      $display("clipped_rect_circle_fill_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $error("timeout with %0d results outstanding", expected_results.size());
    $display("clipped_rect_circle_fill_tb: errors");
    $finish;
  end

endmodule

// ===== clipped_rect_circle_fill.f =====
rtl/crcf_pkg.sv
rtl/crcf_front.sv
rtl/crcf_queue.sv
rtl/crcf_back.sv
rtl/clipped_rect_circle_fill.sv
verif/clipped_rect_circle_fill_tb.sv
